@@ hw/rtl/qdvf_pkg.sv @@
// Package for the quadrature decoder and velocity filter.
// Holds opcodes, sequencer states, register indexes, reset values and helpers.
// No dependencies; used by every module of the block.
`default_nettype none

package qdvf_pkg;

    // Widths fixed by the item and register formats.
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COEF_W      = 24;
    localparam int unsigned PROD_W      = 56;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned PERIOD_COUNT_BITS_DEF = 16;

    // Register reset values.
    localparam logic [23:0] RAD_PER_COUNT_RST      = 24'd26354;
    localparam logic [23:0] INV_COUNTS_PER_REV_RST = 24'd16384;
    localparam logic [15:0] INV_FILTER_TIME_RST    = 16'd25600;
    localparam logic [15:0] SAMPLE_PERIOD_RST      = 16'd655;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_ZERO   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        REG_REVERSE_DIRECTION  = 3'd0,
        REG_RAD_PER_COUNT      = 3'd1,
        REG_INV_COUNTS_PER_REV = 3'd2,
        REG_INV_FILTER_TIME    = 3'd3,
        REG_SAMPLE_PERIOD      = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REVS,
        S_ANGLE,
        S_ACCUM,
        S_DIFF,
        S_VEL,
        S_VSAT,
        S_INTEG,
        S_INTADD,
        S_OUT
    } state_t;

    // Position of an AB level along the Gray cycle 00, 10, 11, 01.
    function automatic logic [1:0] gray_pos(input logic [1:0] ab);
        logic [1:0] pos;
        unique case (ab)
            2'b00:   pos = 2'd0;
            2'b10:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            default: pos = 2'd3;
        endcase
        return pos;
    endfunction

    // Product shifted right by eight with floor, saturated to 32 bits.
    function automatic logic [DATA_W-1:0] sat_shr8(input logic signed [PROD_W-1:0] p);
        logic [DATA_W-1:0] res;
        if ((&p[PROD_W-1:39]) || !(|p[PROD_W-1:39])) begin
            res = p[39:8];
        end else if (p[PROD_W-1]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qdvf_mul.sv @@
// Shared signed by unsigned multiplier with a registered product.
// Depends on qdvf_pkg for the operand and product widths.
`default_nettype none

module qdvf_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [qdvf_pkg::DATA_W-1:0]   op_a,
    input  wire logic        [qdvf_pkg::COEF_W-1:0]   op_b,
    output logic signed      [qdvf_pkg::PROD_W-1:0]   prod_reg
);

    logic signed [qdvf_pkg::COEF_W:0]   op_b_s;
    logic signed [qdvf_pkg::PROD_W-1:0] prod_full;

    // The unsigned coefficient gains a zero sign bit before the signed multiply.
    // With a non-negative coefficient the product always fits in PROD_W bits.
    assign op_b_s    = $signed({1'b0, op_b});
    assign prod_full = op_a * op_b_s;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full;
    end

endmodule

`default_nettype wire

@@ hw/rtl/qdvf_gray.sv @@
// Gray step decoder and saturating per-period count update.
// Depends on qdvf_pkg for the Gray position function.
`default_nettype none

module qdvf_gray #(
    parameter int unsigned PERIOD_COUNT_BITS = qdvf_pkg::PERIOD_COUNT_BITS_DEF
) (
    input  wire logic                                 reverse_direction,
    input  wire logic        [1:0]                    last_ab,
    input  wire logic        [1:0]                    ab_level,
    input  wire logic signed [PERIOD_COUNT_BITS-1:0]  count,
    output logic signed      [PERIOD_COUNT_BITS-1:0]  count_next
);

    localparam logic signed [PERIOD_COUNT_BITS-1:0] CNT_MAX =
        {1'b0, {(PERIOD_COUNT_BITS-1){1'b1}}};
    localparam logic signed [PERIOD_COUNT_BITS-1:0] CNT_MIN =
        {1'b1, {(PERIOD_COUNT_BITS-1){1'b0}}};

    logic [1:0] delta;
    logic       step_up;
    logic       step_down;

    // Distance travelled along the Gray cycle since the previous sample.
    assign delta = qdvf_pkg::gray_pos(ab_level) - qdvf_pkg::gray_pos(last_ab);

    // A single-position move is a step; the direction register swaps its sign.
    always_comb begin
        step_up   = 1'b0;
        step_down = 1'b0;
        unique case (delta)
            2'd1: begin
                step_up   = !reverse_direction;
                step_down = reverse_direction;
            end
            2'd3: begin
                step_up   = reverse_direction;
                step_down = !reverse_direction;
            end
            default: begin
                step_up   = 1'b0;
                step_down = 1'b0;
            end
        endcase
    end

    // Saturating count update.
    always_comb begin
        count_next = count;
        if (step_up && (count != CNT_MAX)) begin
            count_next = count + PERIOD_COUNT_BITS'(1);
        end else if (step_down && (count != CNT_MIN)) begin
            count_next = count - PERIOD_COUNT_BITS'(1);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_decoder_velocity_filter_unit.sv @@
// Quadrature decoder with velocity filter: top level, sequencer and state registers.
// Depends on qdvf_pkg, qdvf_gray and qdvf_mul.
// Sequence: a sample, zero or unused opcode goes from S_IDLE to S_OUT; a period tick passes
// S_REVS to S_INTADD first, as its four products pass in turn through one multiplier.
// One word in work at once; S_OUT waits for a free output register, then returns to S_IDLE.
// Reset (aresetn low at a clock edge) clears counts, filter state and output; registers reload.
`default_nettype none

module quadrature_decoder_velocity_filter_unit #(
    parameter int unsigned PERIOD_COUNT_BITS = qdvf_pkg::PERIOD_COUNT_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input words.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [7:0]                            s_axis_tdata,  // [1:0] ab_level
    input  wire logic [1:0]                            s_axis_tuser,  // [1:0] opcode
    // Result words.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] total_count, [63:32] angle, [95:64] velocity, [127:96] revs_per_period
    output logic [127:0]                               m_axis_tdata,
    // Configuration writes.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [qdvf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [qdvf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned DW = qdvf_pkg::DATA_W;

    // Configuration registers.
    logic        reverse_direction_reg;
    logic [23:0] rad_per_count_reg;
    logic [23:0] inv_counts_per_rev_reg;
    logic [15:0] inv_filter_time_reg;
    logic [15:0] sample_period_reg;

    // Sequencer and datapath state.
    qdvf_pkg::state_t                  state_reg, state_next;
    logic [1:0]                        last_ab_reg, last_ab_next;
    logic signed [PERIOD_COUNT_BITS-1:0] period_count_reg, period_count_next;
    logic [DW-1:0]                     count_total_reg, count_total_next;
    logic [DW-1:0]                     angle_acc_reg, angle_acc_next;
    logic [DW-1:0]                     integrator_reg, integrator_next;
    logic [DW-1:0]                     velocity_reg, velocity_next;
    logic [DW-1:0]                     revs_reg, revs_next;
    logic [DW-1:0]                     diff_reg, diff_next;
    logic                              m_valid_reg, m_valid_next;
    logic [127:0]                      m_data_reg, m_data_next;

    logic                                   in_fire;
    logic                                   out_free;
    logic [1:0]                             in_opcode;
    logic [1:0]                             in_ab;
    logic signed [PERIOD_COUNT_BITS-1:0]    count_stepped;
    logic signed [DW-1:0]                   count_ext;
    logic signed [DW-1:0]                   mul_a;
    logic        [qdvf_pkg::COEF_W-1:0]     mul_b;
    logic signed [qdvf_pkg::PROD_W-1:0]     prod_reg;

    assign in_opcode     = s_axis_tuser;
    assign in_ab         = s_axis_tdata[1:0];
    assign s_axis_tready = (state_reg == qdvf_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign count_ext     = DW'(period_count_reg);

    // Step decoder for AB samples.
    qdvf_gray #(
        .PERIOD_COUNT_BITS (PERIOD_COUNT_BITS)
    ) u_gray (
        .reverse_direction (reverse_direction_reg),
        .last_ab           (last_ab_reg),
        .ab_level          (in_ab),
        .count             (period_count_reg),
        .count_next        (count_stepped)
    );

    // The one multiplier shared by every product of a period tick.
    qdvf_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // Operand selection for the multiplier.
    always_comb begin
        unique case (state_reg)
            qdvf_pkg::S_ANGLE: begin
                mul_a = count_ext;
                mul_b = rad_per_count_reg;
            end
            qdvf_pkg::S_VEL: begin
                mul_a = $signed(diff_reg);
                mul_b = {8'd0, inv_filter_time_reg};
            end
            qdvf_pkg::S_INTEG: begin
                mul_a = $signed(velocity_reg);
                mul_b = {8'd0, sample_period_reg};
            end
            default: begin
                mul_a = count_ext;
                mul_b = inv_counts_per_rev_reg;
            end
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qdvf_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (in_opcode == qdvf_pkg::OP_TICK) begin
                        state_next = qdvf_pkg::S_REVS;
                    end else begin
                        state_next = qdvf_pkg::S_OUT;
                    end
                end
            end
            qdvf_pkg::S_REVS:   state_next = qdvf_pkg::S_ANGLE;
            qdvf_pkg::S_ANGLE:  state_next = qdvf_pkg::S_ACCUM;
            qdvf_pkg::S_ACCUM:  state_next = qdvf_pkg::S_DIFF;
            qdvf_pkg::S_DIFF:   state_next = qdvf_pkg::S_VEL;
            qdvf_pkg::S_VEL:    state_next = qdvf_pkg::S_VSAT;
            qdvf_pkg::S_VSAT:   state_next = qdvf_pkg::S_INTEG;
            qdvf_pkg::S_INTEG:  state_next = qdvf_pkg::S_INTADD;
            qdvf_pkg::S_INTADD: state_next = qdvf_pkg::S_OUT;
            qdvf_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = qdvf_pkg::S_IDLE;
                end
            end
            default: state_next = qdvf_pkg::S_IDLE;
        endcase
    end

    // Datapath and output register updates for each step of the sequence.
    always_comb begin
        last_ab_next      = last_ab_reg;
        period_count_next = period_count_reg;
        count_total_next  = count_total_reg;
        angle_acc_next    = angle_acc_reg;
        integrator_next   = integrator_reg;
        velocity_next     = velocity_reg;
        revs_next         = revs_reg;
        diff_next         = diff_reg;
        m_data_next       = m_data_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            qdvf_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (in_opcode)
                        qdvf_pkg::OP_SAMPLE: begin
                            period_count_next = count_stepped;
                            last_ab_next      = in_ab;
                        end
                        qdvf_pkg::OP_ZERO: begin
                            period_count_next = '0;
                            count_total_next  = '0;
                            angle_acc_next    = '0;
                            integrator_next   = '0;
                        end
                        default: begin
                            // A tick starts the sequence; the unused opcode changes nothing.
                        end
                    endcase
                end
            end
            qdvf_pkg::S_ANGLE: begin
                revs_next = qdvf_pkg::sat_shr8(prod_reg);
            end
            qdvf_pkg::S_ACCUM: begin
                angle_acc_next    = angle_acc_reg + prod_reg[39:8];
                count_total_next  = count_total_reg + count_ext;
                period_count_next = '0;
            end
            qdvf_pkg::S_DIFF: begin
                diff_next = angle_acc_reg - integrator_reg;
            end
            qdvf_pkg::S_VSAT: begin
                velocity_next = qdvf_pkg::sat_shr8(prod_reg);
            end
            qdvf_pkg::S_INTADD: begin
                integrator_next = integrator_reg + prod_reg[47:16];
            end
            qdvf_pkg::S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {revs_reg, velocity_reg, angle_acc_reg, count_total_reg};
                end
            end
            default: begin
                // Multiply steps only load the shared unit.
            end
        endcase
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_direction_reg  <= 1'b0;
            rad_per_count_reg      <= qdvf_pkg::RAD_PER_COUNT_RST;
            inv_counts_per_rev_reg <= qdvf_pkg::INV_COUNTS_PER_REV_RST;
            inv_filter_time_reg    <= qdvf_pkg::INV_FILTER_TIME_RST;
            sample_period_reg      <= qdvf_pkg::SAMPLE_PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                qdvf_pkg::REG_REVERSE_DIRECTION:  reverse_direction_reg  <= cfg_data[0];
                qdvf_pkg::REG_RAD_PER_COUNT:      rad_per_count_reg      <= cfg_data;
                qdvf_pkg::REG_INV_COUNTS_PER_REV: inv_counts_per_rev_reg <= cfg_data;
                qdvf_pkg::REG_INV_FILTER_TIME:    inv_filter_time_reg    <= cfg_data[15:0];
                qdvf_pkg::REG_SAMPLE_PERIOD:      sample_period_reg      <= cfg_data[15:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Sequencer, position and filter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= qdvf_pkg::S_IDLE;
            last_ab_reg      <= '0;
            period_count_reg <= '0;
            count_total_reg  <= '0;
            angle_acc_reg    <= '0;
            integrator_reg   <= '0;
            velocity_reg     <= '0;
            revs_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            last_ab_reg      <= last_ab_next;
            period_count_reg <= period_count_next;
            count_total_reg  <= count_total_next;
            angle_acc_reg    <= angle_acc_next;
            integrator_reg   <= integrator_next;
            velocity_reg     <= velocity_next;
            revs_reg         <= revs_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        diff_reg   <= diff_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/quadrature_decoder_velocity_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature decoder and velocity filter unit.
// Holds the stream drivers, the register writer and a scoreboard with its own predictor.
// Depends on qdvf_pkg and the quadrature_decoder_velocity_filter_unit RTL.

module quadrature_decoder_velocity_filter_unit_tb;

    localparam int unsigned PC_BITS         = qdvf_pkg::PERIOD_COUNT_BITS_DEF;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          STALL_LIMIT     = 4000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          PHASE_WORDS     = 200;
    localparam int          NUM_PHASES      = 8;
    localparam int          NUM_DIRECTED    = 21;

    // Directed words: opcode in the upper two bits, AB level in the lower two.
    localparam logic [3:0] DIRECTED [NUM_DIRECTED] = '{
        {qdvf_pkg::OP_SAMPLE, 2'b00}, {qdvf_pkg::OP_SAMPLE, 2'b10},
        {qdvf_pkg::OP_SAMPLE, 2'b11}, {qdvf_pkg::OP_SAMPLE, 2'b01},
        {qdvf_pkg::OP_SAMPLE, 2'b00}, {qdvf_pkg::OP_SAMPLE, 2'b01},
        {qdvf_pkg::OP_SAMPLE, 2'b11}, {qdvf_pkg::OP_SAMPLE, 2'b00},
        {qdvf_pkg::OP_SAMPLE, 2'b10}, {qdvf_pkg::OP_SAMPLE, 2'b01},
        {qdvf_pkg::OP_TICK, 2'b11},   {qdvf_pkg::OP_SAMPLE, 2'b10},
        {qdvf_pkg::OP_SAMPLE, 2'b00}, {qdvf_pkg::OP_TICK, 2'b00},
        {OP_UNUSED, 2'b11},           {OP_UNUSED, 2'b00},
        {qdvf_pkg::OP_ZERO, 2'b10},   {qdvf_pkg::OP_SAMPLE, 2'b01},
        {qdvf_pkg::OP_TICK, 2'b01},   {qdvf_pkg::OP_ZERO, 2'b11},
        {qdvf_pkg::OP_SAMPLE, 2'b00}
    };

    // Tracks the decoder and filter state and holds the result words still owed.
    class qd_scoreboard;
        bit           rev_dir;
        bit [23:0]    rad_per_cnt;
        bit [23:0]    inv_cpr;
        bit [15:0]    inv_tf;
        bit [15:0]    ts;
        bit [1:0]     prev_ab;
        longint       period_cnt;
        bit [31:0]    total;
        bit [31:0]    angle;
        bit [31:0]    integ;
        bit [31:0]    velocity;
        bit [31:0]    revs;
        logic [127:0] owed_words [$];
        int           errors;
        string        field_names [4];

        function new();
            rev_dir     = 1'b0;
            rad_per_cnt = qdvf_pkg::RAD_PER_COUNT_RST;
            inv_cpr     = qdvf_pkg::INV_COUNTS_PER_REV_RST;
            inv_tf      = qdvf_pkg::INV_FILTER_TIME_RST;
            ts          = qdvf_pkg::SAMPLE_PERIOD_RST;
            prev_ab     = '0;
            period_cnt  = 0;
            total       = '0;
            angle       = '0;
            integ       = '0;
            velocity    = '0;
            revs        = '0;
            errors      = 0;
            field_names = '{"total_count", "angle", "velocity", "revs_per_period"};
        endfunction

        function void set_reg(qdvf_pkg::cfg_index_t idx, logic [23:0] val);
            case (idx)
                qdvf_pkg::REG_REVERSE_DIRECTION:  rev_dir     = val[0];
                qdvf_pkg::REG_RAD_PER_COUNT:      rad_per_cnt = val;
                qdvf_pkg::REG_INV_COUNTS_PER_REV: inv_cpr     = val;
                qdvf_pkg::REG_INV_FILTER_TIME:    inv_tf      = val[15:0];
                qdvf_pkg::REG_SAMPLE_PERIOD:      ts          = val[15:0];
                default: ;
            endcase
        endfunction

        // Position along the Gray cycle 00, 10, 11, 01.
        function bit [1:0] cycle_pos(bit [1:0] ab);
            return {ab[0], ab[1] ^ ab[0]};
        endfunction

        function bit [31:0] clamp32(longint x);
            if (x > 64'sh7FFF_FFFF)
                return 32'h7FFF_FFFF;
            if (x < -64'sh8000_0000)
                return 32'h8000_0000;
            return x[31:0];
        endfunction

        // Advance the state by one accepted word and queue the result it owes.
        function void note_input(logic [1:0] op, logic [1:0] ab);
            longint    cmax;
            longint    step;
            longint    c;
            longint    t;
            bit [1:0]  d;
            bit [31:0] gap;
            cmax = (longint'(1) <<< (PC_BITS - 1)) - 1;
            case (op)
                qdvf_pkg::OP_SAMPLE: begin
                    d    = cycle_pos(ab) - cycle_pos(prev_ab);
                    step = (d == 2'd1) ? 1 : ((d == 2'd3) ? -1 : 0);
                    if (rev_dir)
                        step = -step;
                    period_cnt = period_cnt + step;
                    if (period_cnt > cmax)
                        period_cnt = cmax;
                    if (period_cnt < -cmax - 1)
                        period_cnt = -cmax - 1;
                    prev_ab = ab;
                end
                qdvf_pkg::OP_TICK: begin
                    c     = period_cnt;
                    revs  = clamp32((c * longint'(inv_cpr)) >>> 8);
                    total = total + c[31:0];
                    t     = (c * longint'(rad_per_cnt)) >>> 8;
                    angle = angle + t[31:0];
                    gap   = angle - integ;
                    t     = (longint'($signed(gap)) * longint'(inv_tf)) >>> 8;
                    velocity = clamp32(t);
                    t     = (longint'($signed(velocity)) * longint'(ts)) >>> 16;
                    integ = integ + t[31:0];
                    period_cnt = 0;
                end
                qdvf_pkg::OP_ZERO: begin
                    period_cnt = 0;
                    total      = '0;
                    angle      = '0;
                    integ      = '0;
                end
                default: ;
            endcase
            owed_words.push_back({revs, velocity, angle, total});
        endfunction

        // Compare one result word with the oldest word owed.
        function void check_result(logic [127:0] got);
            logic [127:0] want;
            bit           bad;
            if (owed_words.size() == 0) begin
                if (errors < 10)
                    $display("%0t: result word %h arrived with nothing owed", $realtime, got);
                errors++;
                return;
            end
            want = owed_words.pop_front();
            bad  = 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (got[32*i +: 32] !== want[32*i +: 32]) begin
                    if (errors < 10)
                        $display("%0t: %s expected %h, got %h", $realtime, field_names[i],
                                 want[32*i +: 32], got[32*i +: 32]);
                    bad = 1'b1;
                end
            end
            if (bad)
                errors++;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // [1:0] ab_level
    logic [1:0]           s_axis_tuser  = '0;  // [1:0] opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] total_count, [63:32] angle, [95:64] velocity, [127:96] revs_per_period
    logic [127:0]         m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    qdvf_pkg::cfg_index_t cfg_index     = qdvf_pkg::REG_REVERSE_DIRECTION;
    logic [23:0]          cfg_data      = '0;

    qd_scoreboard sb;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_off_req  = 1'b0;
    logic [1:0]   last_sent_ab  = 2'b00;
    bit           forward       = 1'b1;

    quadrature_decoder_velocity_filter_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Next AB level one Gray step forwards or backwards.
    function automatic logic [1:0] step_ab(logic [1:0] ab, bit fwd);
        case (ab)
            2'b00:   return fwd ? 2'b10 : 2'b01;
            2'b10:   return fwd ? 2'b11 : 2'b00;
            2'b11:   return fwd ? 2'b01 : 2'b10;
            default: return fwd ? 2'b00 : 2'b11;
        endcase
    endfunction

    // Offer one input word; called and returns at a falling edge, leaving tvalid high.
    task automatic send_word(logic [1:0] op, logic [1:0] ab);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, ab};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(op, ab);
        if (op == qdvf_pkg::OP_SAMPLE)
            last_sent_ab = ab;
        @(negedge aclk);
    endtask

    // Mostly clean encoder motion with random ticks, plus noise and stray commands.
    task automatic send_random_word();
        int r;
        r = $urandom_range(999);
        if (r < 60) begin
            send_word(qdvf_pkg::OP_TICK, 2'($urandom_range(3)));
        end else if (r < 70) begin
            send_word(qdvf_pkg::OP_ZERO, 2'($urandom_range(3)));
        end else if (r < 80) begin
            send_word(OP_UNUSED, 2'($urandom_range(3)));
        end else if (r < 130) begin
            send_word(qdvf_pkg::OP_SAMPLE, 2'($urandom_range(3)));
        end else if (r < 150) begin
            send_word(qdvf_pkg::OP_SAMPLE, last_sent_ab);
        end else begin
            if ($urandom_range(99) < 5)
                forward = !forward;
            send_word(qdvf_pkg::OP_SAMPLE, step_ab(last_sent_ab, forward));
        end
    endtask

    // Stop offering and wait for every owed result word.
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(qdvf_pkg::cfg_index_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(bit rev, logic [23:0] rad, logic [23:0] icpr,
                             logic [15:0] itf, logic [15:0] sp);
        write_reg(qdvf_pkg::REG_REVERSE_DIRECTION, {23'b0, rev});
        write_reg(qdvf_pkg::REG_RAD_PER_COUNT, rad);
        write_reg(qdvf_pkg::REG_INV_COUNTS_PER_REV, icpr);
        write_reg(qdvf_pkg::REG_INV_FILTER_TIME, {8'b0, itf});
        write_reg(qdvf_pkg::REG_SAMPLE_PERIOD, {8'b0, sp});
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog on cycles in which no word moves on any channel.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 57;

        // Directed words under the reset register values.
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(DIRECTED[i][3:2], DIRECTED[i][1:0]);
        drain_words();

        // Random phases under changing register settings and idling profiles.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 18;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: configure(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
                1: configure(1'b0, 24'h0, 24'h0, 16'h0, 16'h0);
                2: configure(1'b0, qdvf_pkg::RAD_PER_COUNT_RST,
                             qdvf_pkg::INV_COUNTS_PER_REV_RST,
                             qdvf_pkg::INV_FILTER_TIME_RST, qdvf_pkg::SAMPLE_PERIOD_RST);
                default: configure(1'($urandom_range(1)), 24'($urandom()), 24'($urandom()),
                                   16'($urandom()), 16'($urandom()));
            endcase
            if (p == 0)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_word();
            drain_words();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
